[rtl/modular_inverse_ext_euclid_assert.svh]
// Assertion macros for the modular inverse block
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

// consequent must hold in the following cycle
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold at a later cycle than the antecedent
`define MIE_ASSERT_THREE(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

[rtl/mie_pkg.sv]
// Types and constants shared by the modular inverse block
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    localparam int unsigned VALUE_W       = 16;
    localparam int unsigned MODULUS_RESET = 65537;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_REDUCE,
        ST_SWAP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;         // take a new request
        logic align_mode;   // comparator checks doubled divisor
        logic align_shift;  // double divisor and coefficient
        logic reduce_step;  // conditional subtract, then halve
        logic swap;         // end of one Euclid step
        logic finish;       // final correction into the output register
    } ctrl_t;

    typedef struct packed {
        logic dsh_zero;
        logic le;
        logic sh_zero;
    } stat_t;

endpackage

`default_nettype wire

[rtl/modular_inverse_ext_euclid.sv]
// Top level of the modular inverse block (extended Euclid, iterative)
//
// Channels: a configuration write channel (cfg_valid/cfg_ready, modulus)
// that is always ready, an input channel (in_valid/in_ready, value) and a
// result channel (out_valid/out_ready, inverse). Write the modulus only
// while no request is in flight.
// Each request runs the extended Euclid algorithm on (modulus, value).
// Every Euclid step is a restoring division on one shared comparator and
// subtractor: the divisor is doubled until doubling it again would pass the
// remainder, then subtracted back down one quotient bit at a time, then a
// swap state exchanges the operands. Value 0 goes straight to finish.
// One request at a time: in_ready is high only while the sequencer idles.
// The result sits in an output register, so a new request may be taken
// while the previous result waits; if the receiver stalls, the sequencer
// holds its last cycle until the output register frees up.
// Reset clears the sequencer and output valid and sets the modulus to 65537.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_ext_euclid
    import mie_pkg::*;
#(
    parameter int MOD_WIDTH = 17
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [MOD_WIDTH-1:0] modulus,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [VALUE_W-1:0]   value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [MOD_WIDTH-1:0]      inverse
);

    `include "modular_inverse_ext_euclid_assert.svh"

    localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(MODULUS_RESET);

    logic [MOD_WIDTH-1:0] modulus_reg, modulus_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MOD_WIDTH-1:0] inverse_reg, inverse_next;
    logic [MOD_WIDTH-1:0] result;
    logic                 out_free;
    ctrl_t                ctl;
    stat_t                stat;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        modulus_next = (cfg_valid && cfg_ready) ? modulus : modulus_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        inverse_next   = inverse_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
            inverse_next   = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inverse_reg <= inverse_next;
    end

    mie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    mie_unit #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_unit (
        .clk     (clk),
        .ctl     (ctl),
        .modulus (modulus_reg),
        .value   (value),
        .stat    (stat),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign inverse   = inverse_reg;

    // sequencer is busy straight after taking a request
    `MIE_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready while busy")

    // zero value with a free output gives a zero result via the align and finish states
    `MIE_ASSERT_THREE(a_zero_value, in_valid && in_ready && (value == '0) && !out_valid_reg, out_valid_reg && (inverse_reg == '0), "zero value gave wrong result")

endmodule

`default_nettype wire

[rtl/mie_ctrl.sv]
// Sequencer for the modular inverse block
`timescale 1ns / 1ps
`default_nettype none

module mie_ctrl
    import mie_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output logic       in_ready,
    output ctrl_t      ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (stat.dsh_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (!stat.le)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (stat.sh_zero)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                state_next = ST_ALIGN;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        ctl             = '0;
        ctl.load        = (state_reg == ST_IDLE) && in_valid;
        ctl.align_mode  = (state_reg == ST_ALIGN);
        ctl.align_shift = (state_reg == ST_ALIGN) && !stat.dsh_zero && stat.le;
        ctl.reduce_step = (state_reg == ST_REDUCE);
        ctl.swap        = (state_reg == ST_SWAP);
        ctl.finish      = (state_reg == ST_FINISH) && out_free;
    end

endmodule

`default_nettype wire

[rtl/mie_unit.sv]
// Shared compare/subtract/shift datapath for the extended Euclid iteration
`timescale 1ns / 1ps
`default_nettype none

module mie_unit
    import mie_pkg::*;
#(
    parameter int MOD_WIDTH = 17
)
(
    input  wire logic                 clk,
    input  wire ctrl_t                ctl,
    input  wire logic [MOD_WIDTH-1:0] modulus,
    input  wire logic [VALUE_W-1:0]   value,
    output stat_t                     stat,
    output logic [MOD_WIDTH-1:0]      result
);

    localparam int OW = (MOD_WIDTH > VALUE_W) ? MOD_WIDTH : VALUE_W;
    localparam int CW = OW + 2;
    localparam int SW = $clog2(OW);

    // num: running remainder, den: divisor of this step, dsh: divisor shifted up
    logic [OW-1:0]        num_reg, num_next;
    logic [OW-1:0]        den_reg, den_next;
    logic [OW-1:0]        dsh_reg, dsh_next;
    logic [SW-1:0]        sh_reg, sh_next;
    logic signed [CW-1:0] cp_reg, cp_next;
    logic signed [CW-1:0] cc_reg, cc_next;
    logic signed [CW-1:0] csh_reg, csh_next;

    logic [OW:0]          cmp_a;
    logic                 le;
    logic [OW-1:0]        diff;
    logic signed [CW-1:0] cdiff;
    logic signed [CW-1:0] corr;

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        dsh_reg <= dsh_next;
        sh_reg  <= sh_next;
        cp_reg  <= cp_next;
        cc_reg  <= cc_next;
        csh_reg <= csh_next;
    end

    // one comparator: doubled divisor while aligning, divisor while reducing
    assign cmp_a = ctl.align_mode ? {dsh_reg, 1'b0} : {1'b0, dsh_reg};
    assign le    = (cmp_a <= {1'b0, num_reg});
    assign diff  = num_reg - dsh_reg;
    assign cdiff = cp_reg - csh_reg;

    assign stat.dsh_zero = (dsh_reg == '0);
    assign stat.le       = le;
    assign stat.sh_zero  = (sh_reg == '0);

    assign corr   = cp_reg + $signed(CW'(modulus));
    assign result = cp_reg[CW-1] ? corr[MOD_WIDTH-1:0] : cp_reg[MOD_WIDTH-1:0];

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        dsh_next = dsh_reg;
        sh_next  = sh_reg;
        cp_next  = cp_reg;
        cc_next  = cc_reg;
        csh_next = csh_reg;
        if (ctl.load)
        begin
            num_next = OW'(modulus);
            den_next = OW'(value);
            dsh_next = OW'(value);
            sh_next  = '0;
            cp_next  = '0;
            cc_next  = CW'(1);
            csh_next = CW'(1);
        end
        else if (ctl.align_shift)
        begin
            dsh_next = {dsh_reg[OW-2:0], 1'b0};
            csh_next = csh_reg <<< 1;
            sh_next  = sh_reg + SW'(1);
        end
        else if (ctl.reduce_step)
        begin
            // quotient bit set: remainder and coefficient both take the subtract
            if (le)
            begin
                num_next = diff;
                cp_next  = cdiff;
            end
            if (sh_reg != '0)
            begin
                dsh_next = {1'b0, dsh_reg[OW-1:1]};
                csh_next = csh_reg >>> 1;
                sh_next  = sh_reg - SW'(1);
            end
        end
        else if (ctl.swap)
        begin
            num_next = den_reg;
            den_next = num_reg;
            dsh_next = num_reg;
            sh_next  = '0;
            cp_next  = cc_reg;
            cc_next  = cp_reg;
            csh_next = cp_reg;
        end
    end

endmodule

`default_nettype wire

[tb/mie_checker.sv]
// Checker for the modular inverse block: tracks the modulus, predicts each inverse, compares
`timescale 1ns / 1ps

module mie_checker
    import mie_pkg::*;
#(
    parameter int MOD_W = 17
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [MOD_W-1:0]   modulus,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [MOD_W-1:0]   inverse,
    output int                      errors,
    output int                      outstanding
);

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [MOD_W-1:0]   modulus;
        logic [MOD_W-1:0]   inverse;
    } inverse_req_t;

    logic [MOD_W-1:0] cur_modulus;
    inverse_req_t     pending_inverses[$];

    // Extended Euclid on (m, v), tracking the coefficient of v
    function automatic logic [MOD_W-1:0] predict_inverse(logic [MOD_W-1:0] m,
                                                         logic [VALUE_W-1:0] v);
        longint num;
        longint den;
        longint quo;
        longint rem;
        longint coef_prev;
        longint coef_cur;
        longint coef_next;
        num       = longint'(m);
        den       = longint'(v);
        coef_prev = 0;
        coef_cur  = 1;
        while (den > 0)
        begin
            quo       = num / den;
            rem       = num - quo * den;
            coef_next = coef_prev - quo * coef_cur;
            num       = den;
            den       = rem;
            coef_prev = coef_cur;
            coef_cur  = coef_next;
        end
        // correction uses the full modulus, not a 16-bit copy
        if (coef_prev < 0)
            coef_prev += longint'(m);
        return MOD_W'(coef_prev);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        inverse_req_t req;
        if (!rst_n)
        begin
            cur_modulus = MOD_W'(MODULUS_RESET);
            pending_inverses.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_inverses.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual inverse %0d",
                             $time, inverse);
                    errors++;
                end
                else
                begin
                    req = pending_inverses.pop_front();
                    if (inverse !== req.inverse)
                    begin
                        $display("%0t: inverse of %0d mod %0d: expected %0d, actual %0d",
                                 $time, req.value, req.modulus, req.inverse, inverse);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                req.value   = value;
                req.modulus = cur_modulus;
                req.inverse = predict_inverse(cur_modulus, value);
                pending_inverses.push_back(req);
            end
            if (cfg_valid && cfg_ready)
                cur_modulus = modulus;
            outstanding = pending_inverses.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Top of the modular inverse testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps

module tb_top;
    import mie_pkg::*;

    localparam int MOD_W        = 17;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int ITEMS_PER_PH = 75;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [MOD_W-1:0]   modulus;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [MOD_W-1:0]   inverse;

    int errors;
    int outstanding;
    bit no_idle;
    bit long_hold;

    modular_inverse_ext_euclid #(
        .MOD_WIDTH (MOD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .inverse   (inverse)
    );

    mie_checker #(
        .MOD_W (MOD_W)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .modulus     (modulus),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .inverse     (inverse),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(logic [MOD_W-1:0] m);
        int r;
        int centre;
        r = $urandom_range(0, 9);
        if (r == 0)
            return VALUE_W'($urandom_range(0, 15));
        else if (r == 1)
            return VALUE_W'($urandom_range(65520, 65535));
        else if (r == 2)
        begin
            centre = (m > 65535) ? 65527 : ((m < 8) ? 8 : int'(m));
            return VALUE_W'($urandom_range(centre - 8, centre + 8));
        end
        else
            return VALUE_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(logic [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // let every result come home so the modulus can be changed safely
    task automatic drain();
        in_valid <= 1'b0;
        // wait for a clock edge first so the count already holds the last request
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] m);
        drain();
        cfg_valid <= 1'b1;
        modulus   <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver
    initial
    begin
        int  hold_cnt;
        bit  long_done;
        hold_cnt  = 0;
        long_done = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold && !long_done)
            begin
                long_done = 1'b1;
                hold_cnt  = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (no_idle || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                hold_cnt  = pick_gap();
            end
        end
    end

    // watchdog: cycles with no request, result or register write accepted
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [MOD_W-1:0] phase_mod[8];
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        modulus   <= '0;
        in_valid  <= 1'b0;
        value     <= '0;
        no_idle   = 1'b0;
        long_hold = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default modulus 65537: zero, ones, edges, alternating bits
        send_request(16'd0);
        send_request(16'd1);
        send_request(16'd2);
        send_request(16'd3);
        send_request(16'hFFFF);
        send_request(16'h8000);
        send_request(16'hAAAA);
        send_request(16'h5555);
        send_request(16'h7FFF);

        // smallest modulus: values below, at and above it
        write_modulus(MOD_W'(2));
        send_request(16'd0);
        send_request(16'd1);
        send_request(16'd2);
        send_request(16'hFFFF);

        // value equal to, a multiple of and just below the modulus
        write_modulus(MOD_W'(257));
        send_request(16'd256);
        send_request(16'd257);
        send_request(16'd514);
        send_request(16'd1);
        send_request(16'hFFFF);

        // even modulus: even values have no inverse
        write_modulus(MOD_W'(65536));
        send_request(16'd2);
        send_request(16'h8000);
        send_request(16'd4097);
        send_request(16'hFFFF);
        send_request(16'd0);

        phase_mod[0] = MOD_W'(65537);
        phase_mod[1] = MOD_W'(2);
        phase_mod[2] = MOD_W'($urandom_range(2, 65537));
        phase_mod[3] = MOD_W'($urandom_range(2, 65537));
        phase_mod[4] = MOD_W'(65536);
        phase_mod[5] = MOD_W'($urandom_range(2, 300));
        phase_mod[6] = MOD_W'(3);
        phase_mod[7] = MOD_W'(65537);

        for (int ph = 0; ph < 8; ph++)
        begin
            write_modulus(phase_mod[ph]);
            no_idle = (ph == 3);
            for (int i = 0; i < ITEMS_PER_PH; i++)
            begin
                // fill the block while the receiver sits out a long stretch
                if (ph == 0 && i == 20)
                    long_hold = 1'b1;
                send_request(pick_value(phase_mod[ph]));
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
